### rtl/chacha20_block_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// ChaCha block generator assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_BLOCK_GENERATOR_UNIT_MACROS_SVH
`define CHACHA20_BLOCK_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, reset-gated.
`define CHK_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-gated.
`define CHK_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha package
// Shared widths, command and lane types, and the quarter-round helper.
// ----------------------------------------------------------------------------
package chacha_pkg;

    localparam int WORD_W         = 32;
    localparam int IDX_W          = 4;
    localparam int NUM_WORDS      = 16;
    localparam int NUM_LANES      = 4;
    localparam int DEFAULT_ROUNDS = 20;

    // command queue between front and core (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // block counter words
    localparam int CTR_LO_WORD = 12;
    localparam int CTR_HI_WORD = 13;

    // quarter-round rotate amounts
    localparam int unsigned ROT_1 = 16;
    localparam int unsigned ROT_2 = 12;
    localparam int unsigned ROT_3 = 8;
    localparam int unsigned ROT_4 = 7;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_GEN  = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic             is_gen;
        logic [IDX_W-1:0] index;
        word_t            value;
    } cmd_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT,
        ST_BUMP
    } core_state_t;

    // shift amount is always a constant at the call site
    function automatic word_t rotl(input word_t v, input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // half a quarter round: first half uses 16/12, second half 8/7
    function automatic quad_t qr_half(input quad_t q, input logic second);
        word_t a1;
        word_t b1;
        word_t c1;
        word_t d1;
        word_t x;
        word_t y;
        quad_t r;
        a1  = q.a + q.b;
        x   = q.d ^ a1;
        d1  = second ? rotl(x, ROT_3) : rotl(x, ROT_1);
        c1  = q.c + d1;
        y   = q.b ^ c1;
        b1  = second ? rotl(y, ROT_4) : rotl(y, ROT_2);
        r.a = a1;
        r.b = b1;
        r.c = c1;
        r.d = d1;
        return r;
    endfunction

endpackage

### rtl/chacha_front.sv
// ----------------------------------------------------------------------------
// ChaCha front end
// Accepts items, decodes the action and queues commands for the core.
// ----------------------------------------------------------------------------
module chacha_front
    import chacha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  logic             action,
    input  logic [IDX_W-1:0] word_index,
    input  word_t            word_value,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  logic             q_pop
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              in_cmd;
    logic              push;

    always_comb
    begin
        in_cmd.is_gen = (action == ACT_GEN);
        in_cmd.index  = word_index;
        in_cmd.value  = word_value;
    end

    assign cmd_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/chacha_core.sv
// ----------------------------------------------------------------------------
// ChaCha core
// Holds the state, runs the rounds and streams out one keystream block.
// ----------------------------------------------------------------------------
module chacha_core
    import chacha_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             key_valid,
    input  logic             key_stall,
    output word_t            key_word,
    output logic [IDX_W-1:0] out_index,
    output logic             last_word
);

    // odd counts round up to a whole double round; four half steps each
    localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
    localparam int HALF_STEPS    = DOUBLE_ROUNDS * 4;
    localparam int STEP_W        = $clog2(HALF_STEPS);

    core_state_t      state_reg;
    core_state_t      state_next;
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0] idx_reg;
    word_t            blk_reg  [NUM_WORDS];
    word_t            work_reg [NUM_WORDS];
    word_t            work_rnd [NUM_WORDS];
    quad_t            lane_in  [NUM_LANES];
    quad_t            lane_out [NUM_LANES];
    word_t            key_word_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             last_word_reg;
    logic             key_valid_reg;

    logic slot_free;
    logic last_step;
    logic last_idx;
    logic diag;
    logic second;
    logic load_en;
    logic copy_en;
    logic round_en;
    logic emit_en;
    logic bump_en;

    assign slot_free = !key_valid_reg || !key_stall;
    assign last_step = (step_reg == STEP_W'(HALF_STEPS - 1));
    assign last_idx  = (idx_reg == IDX_W'(NUM_WORDS - 1));
    assign diag      = step_reg[1];
    assign second    = step_reg[0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.is_gen)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (last_step)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && last_idx)
                begin
                    state_next = ST_BUMP;
                end
            end
            ST_BUMP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_en  = 1'b0;
        copy_en  = 1'b0;
        round_en = 1'b0;
        emit_en  = 1'b0;
        bump_en  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop   = q_valid;
                load_en = q_valid && !q_cmd.is_gen;
                copy_en = q_valid && q_cmd.is_gen;
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
            end
            ST_EMIT:
            begin
                emit_en = slot_free;
            end
            ST_BUMP:
            begin
                bump_en = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // four quarter-round lanes, column or diagonal gather/scatter
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        assign lane_in[k].a = work_reg[k];
        assign lane_in[k].b = diag ? work_reg[4 + ((k + 1) % 4)]  : work_reg[4 + k];
        assign lane_in[k].c = diag ? work_reg[8 + ((k + 2) % 4)]  : work_reg[8 + k];
        assign lane_in[k].d = diag ? work_reg[12 + ((k + 3) % 4)] : work_reg[12 + k];
        assign lane_out[k]  = qr_half(lane_in[k], second);
    end

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_scatter
        assign work_rnd[j]      = lane_out[j].a;
        assign work_rnd[4 + j]  = diag ? lane_out[(j + 3) % 4].b : lane_out[j].b;
        assign work_rnd[8 + j]  = diag ? lane_out[(j + 2) % 4].c : lane_out[j].c;
        assign work_rnd[12 + j] = diag ? lane_out[(j + 1) % 4].d : lane_out[j].d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            key_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                blk_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (copy_en || (round_en && last_step))
            begin
                step_reg <= '0;
            end
            else if (round_en)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (copy_en)
            begin
                idx_reg <= '0;
            end
            else if (emit_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (emit_en)
            begin
                key_valid_reg <= 1'b1;
            end
            else if (!key_stall)
            begin
                key_valid_reg <= 1'b0;
            end
            if (load_en)
            begin
                blk_reg[q_cmd.index] <= q_cmd.value;
            end
            if (bump_en)
            begin
                blk_reg[CTR_LO_WORD] <= blk_reg[CTR_LO_WORD] + 1'b1;
                if (blk_reg[CTR_LO_WORD] == '1)
                begin
                    blk_reg[CTR_HI_WORD] <= blk_reg[CTR_HI_WORD] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (copy_en)
        begin
            work_reg <= blk_reg;
        end
        else if (round_en)
        begin
            work_reg <= work_rnd;
        end
        if (emit_en)
        begin
            key_word_reg  <= work_reg[idx_reg] + blk_reg[idx_reg];
            out_index_reg <= idx_reg;
            last_word_reg <= last_idx;
        end
    end

    assign key_valid = key_valid_reg;
    assign key_word  = key_word_reg;
    assign out_index = out_index_reg;
    assign last_word = last_word_reg;

endmodule

### rtl/chacha20_block_generator_unit.sv
// ----------------------------------------------------------------------------
// ChaCha block generator unit
// Loads a sixteen-word ChaCha state and streams keystream blocks from it.
// ----------------------------------------------------------------------------
// Load item: written to a state word once it leaves the two-entry command queue.
// Generate item: a copy into the working words, the round steps (one half
//   quarter round per lane per cycle), sixteen output words and the block
//   counter update; key_stall can hold the output words.
// The round lanes feed the single output register that the words leave through.
// Reset clears the state words, the queue and the output valid.
module chacha20_block_generator_unit
    import chacha_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS
)
(
    input  logic             clk,
    input  logic             rst_n,
    // item channel
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  logic             action,
    input  logic [IDX_W-1:0] word_index,
    input  word_t            word_value,
    // keystream channel
    output logic             key_valid,
    input  logic             key_stall,
    output word_t            key_word,
    output logic [IDX_W-1:0] out_index,
    output logic             last_word
);

    // front-to-core command handoff
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // Front end: accepts items while the core is busy; stalls only
    // when both queue entries hold commands.
    chacha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .action     (action),
        .word_index (word_index),
        .word_value (word_value),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    // Core: state words, round lanes, output register and the
    // block counter update after the sixteenth word leaves.
    chacha_core #(
        .ROUNDS (ROUNDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_word  (key_word),
        .out_index (out_index),
        .last_word (last_word)
    );

endmodule

### rtl/chacha_checker.sv
// ----------------------------------------------------------------------------
// ChaCha checker
// Port-level assertions on the keystream channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "chacha20_block_generator_unit_macros.svh"

module chacha_checker
    import chacha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_stall,
    input  logic             action,
    input  logic [IDX_W-1:0] word_index,
    input  word_t            word_value,
    input  logic             key_valid,
    input  logic             key_stall,
    input  word_t            key_word,
    input  logic [IDX_W-1:0] out_index,
    input  logic             last_word
);

    logic key_take;
    logic cmd_take;

    assign key_take = key_valid && !key_stall;
    assign cmd_take = cmd_valid && !cmd_stall && (action == ACT_GEN || action == ACT_LOAD)
                      && (word_index == word_index) && (word_value == word_value);

    // stalled output item holds
    `CHK_ASSERT_NEXT(a_key_hold, clk, rst_n, key_valid && key_stall,
        key_valid && $stable(key_word) && $stable(out_index) && $stable(last_word),
        "stalled keystream item changed")

    // last mark only on the final word of a block
    `CHK_ASSERT_IMPL(a_last_pos, clk, rst_n, key_valid && last_word,
        out_index == IDX_W'(NUM_WORDS - 1), "last word mark on wrong position")

    // words of a block come out in order
    `CHK_ASSERT_NEXT(a_word_order, clk, rst_n, key_take && !last_word,
        !key_valid || out_index == $past(out_index) + 1'b1,
        "keystream word out of order")

    // a fresh block starts at word zero
    `CHK_ASSERT_NEXT(a_block_start, clk, rst_n, key_take && last_word && !cmd_take,
        !key_valid || out_index == '0, "keystream block not starting at word zero")

endmodule

bind chacha20_block_generator_unit chacha_checker u_chk (.*);
